// ===== design/esc_pkg.sv =====
package esc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned ADDR_W      = 6;

  typedef enum logic [2:0] {
    REG_TEMP       = 3'd0,
    REG_PRESS_LOW  = 3'd1,
    REG_PRESS_HIGH = 3'd2,
    REG_MIXED      = 3'd3,
    REG_HUM        = 3'd4
  } reg_idx_t;

  // Calibration coefficients, extended to the width of the path that uses them
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
    logic [63:0] p4;
    logic [63:0] p5;
    logic [63:0] p6;
    logic [63:0] p7;
    logic [63:0] p8;
    logic [63:0] p9;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] h4;
    logic [31:0] h5;
    logic [31:0] h6;
  } coef_t;

  // Pre-classified reading set handed from the front to the back
  typedef struct packed {
    logic [31:0] ta;
    logic [31:0] d;
    logic [15:0] hum;
    logic [20:0] pbase;
  } entry_t;

  // Results that ride alongside the pressure divider
  typedef struct packed {
    logic [31:0] tc;
    logic [16:0] hq;
    logic        inv;
    logic        neg;
  } side_t;

  // Partial products of a 64x64 multiply kept modulo 2^64
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } pp_t;

  function automatic coef_t decode_coefs(input logic [47:0] tc, input logic [63:0] pl,
                                         input logic [63:0] ph, input logic [47:0] mx,
                                         input logic [31:0] hm);
    coef_t c;
    c.t1 = {16'd0, tc[15:0]};
    c.t2 = {{16{tc[31]}}, tc[31:16]};
    c.t3 = {{16{tc[47]}}, tc[47:32]};
    c.p1 = {48'd0, pl[15:0]};
    c.p2 = {{48{pl[31]}}, pl[31:16]};
    c.p3 = {{48{pl[47]}}, pl[47:32]};
    c.p4 = {{48{pl[63]}}, pl[63:48]};
    c.p5 = {{48{ph[15]}}, ph[15:0]};
    c.p6 = {{48{ph[31]}}, ph[31:16]};
    c.p7 = {{48{ph[47]}}, ph[47:32]};
    c.p8 = {{48{ph[63]}}, ph[63:48]};
    c.p9 = {{48{mx[15]}}, mx[15:0]};
    c.h1 = {24'd0, mx[23:16]};
    c.h2 = {{16{mx[39]}}, mx[39:24]};
    c.h3 = {24'd0, mx[47:40]};
    c.h4 = {{20{hm[11]}}, hm[11:0]};
    c.h5 = {{20{hm[23]}}, hm[23:12]};
    c.h6 = {{24{hm[31]}}, hm[31:24]};
    return c;
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned k);
    return 32'($signed(x) >>> k);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned k);
    return 64'($signed(x) >>> k);
  endfunction

  // Signed division by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input int unsigned k);
    logic [31:0] bias;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return 32'($signed(x + bias) >>> k);
  endfunction

  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.cr = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
    return p;
  endfunction

  function automatic logic [63:0] mul_fin(input pp_t p);
    return p.ll + {p.cr, 32'd0};
  endfunction

endpackage

// ===== design/esc_if.sv =====
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic [16:0] humidity_q22_10;
  logic        pressure_invalid;

  modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  pressure_invalid, input ready);
  modport sink   (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  pressure_invalid, output ready);
endinterface

// ===== design/env_sensor_compensation.sv =====
// Environmental sensor compensation.
// Channels: sensor_in carries one set of raw readings (temperature, pressure,
// humidity) per transaction; result_out carries one compensated result per
// transaction, in the same order. Both use valid/ready; a transaction moves on
// a clock edge where both are high.
// Calibration coefficients sit in five 64-bit-spaced registers on the APB
// port (byte address 8*i); write them only while no reading is in flight.
// Throughput: one reading set per cycle while result_out does not stall. The front registers the readings,
// a four-entry queue decouples it from the back, and the back is a fixed
// pipeline whose length is set by the pressure divider, a 64-stage restoring
// divider giving one quotient bit per stage.
// Reset (rst, synchronous) clears the coefficients to zero and empties the
// pipeline. When a result waits with result_out.ready low the whole back pipeline holds;
// the queue and front keep taking readings until they fill up, then
// sensor_in.ready drops.
module env_sensor_compensation #(
  parameter int unsigned QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  esc_in_if.sink                     sensor_in,
  esc_out_if.source                  result_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esc_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [47:0] mixed_coeffs;
  logic [31:0] hum_coeffs;

  esc_pkg::coef_t  coefs;
  esc_pkg::entry_t ent;
  esc_pkg::entry_t q_data;
  esc_pkg::reg_idx_t idx;
  logic ent_valid;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = esc_pkg::reg_idx_t'(paddr[esc_pkg::ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign coefs  = esc_pkg::decode_coefs(temp_coeffs, press_coeffs_low, press_coeffs_high,
                                        mixed_coeffs, hum_coeffs);

  // Write coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      mixed_coeffs      <= '0;
      hum_coeffs        <= '0;
    end else if (wr_en) begin
      unique case (idx)
        esc_pkg::REG_TEMP:       temp_coeffs       <= pwdata[47:0];
        esc_pkg::REG_PRESS_LOW:  press_coeffs_low  <= pwdata;
        esc_pkg::REG_PRESS_HIGH: press_coeffs_high <= pwdata;
        esc_pkg::REG_MIXED:      mixed_coeffs      <= pwdata[47:0];
        esc_pkg::REG_HUM:        hum_coeffs        <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      esc_pkg::REG_TEMP:       prdata = {16'd0, temp_coeffs};
      esc_pkg::REG_PRESS_LOW:  prdata = press_coeffs_low;
      esc_pkg::REG_PRESS_HIGH: prdata = press_coeffs_high;
      esc_pkg::REG_MIXED:      prdata = {16'd0, mixed_coeffs};
      esc_pkg::REG_HUM:        prdata = {32'd0, hum_coeffs};
      default:                 prdata = 64'd0;
    endcase
  end

  esc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sensor_in(sensor_in),
    .coefs    (coefs),
    .ent_valid(ent_valid),
    .ent      (ent),
    .ent_full (q_full)
  );

  esc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (ent_valid),
    .wdata  (ent),
    .full   (q_full),
    .q_valid(q_valid),
    .rdata  (q_data),
    .pop    (q_pop)
  );

  esc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .q_valid   (q_valid),
    .e         (q_data),
    .pop       (q_pop),
    .result_out(result_out)
  );

endmodule

// ===== design/esc_front.sv =====
module esc_front (
  input  logic            clk,
  input  logic            rst,
  esc_in_if.sink          sensor_in,
  input  esc_pkg::coef_t  coefs,
  output logic            ent_valid,
  output esc_pkg::entry_t ent,
  input  logic            ent_full
);

  logic push;

  assign push            = ent_valid && !ent_full;
  assign sensor_in.ready = !ent_valid || push;

  // Hold the transaction with its raw humidity and its first temperature and pressure terms
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (sensor_in.ready) begin
      ent_valid <= sensor_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor_in.ready && sensor_in.valid) begin
      ent.ta    <= 32'(sensor_in.raw_temperature >> 3) - (coefs.t1 << 1);
      ent.d     <= 32'(sensor_in.raw_temperature >> 4) - coefs.t1;
      ent.hum   <= sensor_in.raw_humidity;
      ent.pbase <= 21'd1048576 - 21'(sensor_in.raw_pressure);
    end
  end

endmodule

// ===== design/esc_queue.sv =====
module esc_queue #(
  parameter int unsigned DEPTH = esc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  esc_pkg::entry_t wdata,
  output logic            full,
  output logic            q_valid,
  output esc_pkg::entry_t rdata,
  input  logic            pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  esc_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign rdata   = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== design/esc_div.sv =====
module esc_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    num,
  input  logic [63:0]    den,
  input  esc_pkg::side_t side_in,
  output logic           out_valid,
  output logic [63:0]    quo,
  output esc_pkg::side_t side_out
);

  localparam int unsigned N = esc_pkg::DIV_STEPS;

  logic           vld [N+1];
  logic [63:0]    rem [N+1];
  logic [63:0]    dq  [N+1];
  logic [63:0]    dvs [N+1];
  esc_pkg::side_t sd  [N+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign dq[0]  = num;
  assign dvs[0] = den;
  assign sd[0]  = side_in;

  // One quotient bit per stage, restoring
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [64:0] r;
    logic [64:0] diff;

    assign r    = {rem[k], dq[k][63]};
    assign diff = r - {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[64]) begin
          rem[k+1] <= diff[63:0];
          dq[k+1]  <= {dq[k][62:0], 1'b1};
        end else begin
          rem[k+1] <= r[63:0];
          dq[k+1]  <= {dq[k][62:0], 1'b0};
        end
        dvs[k+1] <= dvs[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign quo       = dq[N];
  assign side_out  = sd[N];

endmodule

// ===== design/esc_back.sv =====
module esc_back (
  input  logic            clk,
  input  logic            rst,
  input  esc_pkg::coef_t  coefs,
  input  logic            q_valid,
  input  esc_pkg::entry_t e,
  output logic            pop,
  esc_out_if.source       result_out
);

  logic en;
  logic [12:0] s_vld;
  logic [5:0]  d_vld;

  assign en              = !d_vld[5] || result_out.ready;
  assign pop             = q_valid && en;
  assign result_out.valid = d_vld[5];

  // Pipeline registers, front half
  logic [31:0] s1_a, s1_dd, s2_a, s2_bt, s3_tf, s4_tc, s4_x1, s5_tc, s5_hx, s5_w2a, s5_w3a;
  logic [15:0] s1_hum, s2_hum, s3_hum, s4_hum, s5_hum;
  logic [20:0] s1_pb, s2_pb, s3_pb, s4_pb, s5_pb, s6_pb, s7_pb, s8_pb, s9_pb, s10_pb, s11_pb;
  logic [63:0] s4_v1;
  esc_pkg::pp_t s5_ppa, s5_pp5, s5_pp2, s7_pp6, s7_pp3, s10_pp1;
  logic [31:0] s6_tc, s6_v5n, s6_m, s7_tc, s7_v5, s7_mm, s8_tc, s8_w3b;
  logic [31:0] s9_tc, s9_w3b, s9_qq, s10_tc, s10_w3b, s10_t, s11_tc;
  logic [63:0] s6_a, s6_b5, s6_b2, s7_b5, s7_b2, s8_c6, s8_c3, s8_b5, s8_b2;
  logic [63:0] s9_v2, s9_s, s10_v2, s11_v2, s11_d, s12_den, s12_num;
  logic [16:0] s11_hq, s12_hq;
  logic [31:0] s12_tc;
  logic [31:0] hs;
  logic [31:0] hs_clamp;
  esc_pkg::side_t s13_side;
  logic [63:0] s13_ma, s13_mb;

  // Divider output and back end
  logic           dv_valid;
  logic [63:0]    dv_quo;
  esc_pkg::side_t dv_side;
  esc_pkg::side_t d1_side, d2_side, d3_side, d4_side, d5_side;
  logic [63:0] d1_pr, d2_pr, d2_x, d3_pr, d3_x, d3_e1, d3_f, d4_pr, d4_f, d5_pr, d5_f, d5_e2;
  esc_pkg::pp_t d2_pp9, d2_pp8, d4_ppe;
  logic [63:0] pres;

  // Humidity before the final scaling
  always_comb begin
    hs = s10_w3b - esc_pkg::sdiv_p2(s10_t, 4);
    if (hs[31]) begin
      hs_clamp = 32'd0;
    end else if (hs > 32'd419430400) begin
      hs_clamp = 32'd419430400;
    end else begin
      hs_clamp = hs;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= '0;
      d_vld <= '0;
    end else if (en) begin
      s_vld <= {s_vld[11:0], q_valid};
      d_vld <= {d_vld[4:0], dv_valid};
    end
  end

  // Temperature, humidity and pressure terms ahead of the divider
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a    <= 32'(e.ta * coefs.t2);
      s1_dd   <= 32'(e.d * e.d);
      s1_hum  <= e.hum;
      s1_pb   <= e.pbase;

      s2_a    <= s1_a;
      s2_bt   <= 32'(esc_pkg::asr32(s1_dd, 12) * coefs.t3);
      s2_hum  <= s1_hum;
      s2_pb   <= s1_pb;

      s3_tf   <= esc_pkg::asr32(s2_a, 11) + esc_pkg::asr32(s2_bt, 14);
      s3_hum  <= s2_hum;
      s3_pb   <= s2_pb;

      s4_tc   <= 32'(s3_tf * 32'd5) + 32'd128;
      s4_x1   <= s3_tf - 32'd76800;
      s4_v1   <= {{32{s3_tf[31]}}, s3_tf} - 64'd128000;
      s4_hum  <= s3_hum;
      s4_pb   <= s3_pb;

      s5_tc   <= esc_pkg::asr32(s4_tc, 8);
      s5_hx   <= 32'(coefs.h5 * s4_x1);
      s5_w2a  <= 32'(s4_x1 * coefs.h6);
      s5_w3a  <= 32'(s4_x1 * coefs.h3);
      s5_ppa  <= esc_pkg::mul_pp(s4_v1, s4_v1);
      s5_pp5  <= esc_pkg::mul_pp(s4_v1, coefs.p5);
      s5_pp2  <= esc_pkg::mul_pp(s4_v1, coefs.p2);
      s5_hum  <= s4_hum;
      s5_pb   <= s4_pb;

      s6_tc   <= s5_tc;
      s6_v5n  <= (32'(s5_hum) << 14) - (coefs.h4 << 20) - s5_hx + 32'd16384;
      s6_m    <= 32'(esc_pkg::sdiv_p2(s5_w2a, 10) *
                     (esc_pkg::sdiv_p2(s5_w3a, 11) + 32'd32768));
      s6_a    <= esc_pkg::mul_fin(s5_ppa);
      s6_b5   <= esc_pkg::mul_fin(s5_pp5);
      s6_b2   <= esc_pkg::mul_fin(s5_pp2);
      s6_pb   <= s5_pb;

      s7_tc   <= s6_tc;
      s7_v5   <= esc_pkg::sdiv_p2(s6_v5n, 15);
      s7_mm   <= 32'((esc_pkg::sdiv_p2(s6_m, 10) + 32'd2097152) * coefs.h2) + 32'd8192;
      s7_pp6  <= esc_pkg::mul_pp(s6_a, coefs.p6);
      s7_pp3  <= esc_pkg::mul_pp(s6_a, coefs.p3);
      s7_b5   <= s6_b5;
      s7_b2   <= s6_b2;
      s7_pb   <= s6_pb;

      s8_tc   <= s7_tc;
      s8_w3b  <= 32'(s7_v5 * esc_pkg::sdiv_p2(s7_mm, 14));
      s8_c6   <= esc_pkg::mul_fin(s7_pp6);
      s8_c3   <= esc_pkg::mul_fin(s7_pp3);
      s8_b5   <= s7_b5;
      s8_b2   <= s7_b2;
      s8_pb   <= s7_pb;

      s9_tc   <= s8_tc;
      s9_w3b  <= s8_w3b;
      s9_qq   <= 32'(esc_pkg::sdiv_p2(s8_w3b, 15) * esc_pkg::sdiv_p2(s8_w3b, 15));
      s9_v2   <= s8_c6 + (s8_b5 << 17) + (coefs.p4 << 35);
      s9_s    <= (64'd1 << 47) + esc_pkg::asr64(s8_c3, 8) + (s8_b2 << 12);
      s9_pb   <= s8_pb;

      s10_tc  <= s9_tc;
      s10_w3b <= s9_w3b;
      s10_t   <= 32'(esc_pkg::sdiv_p2(s9_qq, 7) * coefs.h1);
      s10_pp1 <= esc_pkg::mul_pp(s9_s, coefs.p1);
      s10_v2  <= s9_v2;
      s10_pb  <= s9_pb;

      s11_tc  <= s10_tc;
      s11_hq  <= 17'(hs_clamp >> 12);
      s11_d   <= esc_pkg::mul_fin(s10_pp1);
      s11_v2  <= s10_v2;
      s11_pb  <= s10_pb;

      s12_tc  <= s11_tc;
      s12_hq  <= s11_hq;
      s12_den <= esc_pkg::asr64(s11_d, 33);
      s12_num <= 64'(((64'(s11_pb) << 31) - s11_v2) * 64'd3125);

      s13_side.tc  <= s12_tc;
      s13_side.hq  <= (s12_hq > 17'd102400) ? 17'd102400 : s12_hq;
      s13_side.inv <= (s12_den == 64'd0);
      s13_side.neg <= s12_num[63] ^ s12_den[63];
      s13_ma       <= s12_num[63] ? (64'd0 - s12_num) : s12_num;
      s13_mb       <= s12_den[63] ? (64'd0 - s12_den) : s12_den;
    end
  end

  esc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_vld[12]),
    .num      (s13_ma),
    .den      (s13_mb),
    .side_in  (s13_side),
    .out_valid(dv_valid),
    .quo      (dv_quo),
    .side_out (dv_side)
  );

  assign pres = esc_pkg::asr64(d5_pr + esc_pkg::asr64(d5_e2, 25) + esc_pkg::asr64(d5_f, 19), 8)
              + (coefs.p7 << 4);

  // Pressure correction after the divider, then the output register
  always_ff @(posedge clk) begin
    if (en) begin
      d1_pr   <= dv_side.neg ? (64'd0 - dv_quo) : dv_quo;
      d1_side <= dv_side;

      d2_pr   <= d1_pr;
      d2_x    <= esc_pkg::asr64(d1_pr, 13);
      d2_pp9  <= esc_pkg::mul_pp(coefs.p9, esc_pkg::asr64(d1_pr, 13));
      d2_pp8  <= esc_pkg::mul_pp(coefs.p8, d1_pr);
      d2_side <= d1_side;

      d3_pr   <= d2_pr;
      d3_x    <= d2_x;
      d3_e1   <= esc_pkg::mul_fin(d2_pp9);
      d3_f    <= esc_pkg::asr64(esc_pkg::mul_fin(d2_pp8), 0);
      d3_side <= d2_side;

      d4_pr   <= d3_pr;
      d4_f    <= d3_f;
      d4_ppe  <= esc_pkg::mul_pp(d3_e1, d3_x);
      d4_side <= d3_side;

      d5_pr   <= d4_pr;
      d5_f    <= d4_f;
      d5_e2   <= esc_pkg::mul_fin(d4_ppe);
      d5_side <= d4_side;

      result_out.temperature_centi <= d5_side.tc;
      result_out.humidity_q22_10   <= d5_side.hq;
      result_out.pressure_invalid  <= d5_side.inv;
      result_out.pressure_q24_8    <= d5_side.inv ? 32'd0 : pres[31:0];
    end
  end

endmodule

// ===== test/env_sensor_compensation_checker.sv =====
module env_sensor_compensation_checker (
  input  logic                       clk,
  input  logic                       rst,
  esc_in_if                          sensor_mon,
  esc_out_if                         result_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esc_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic [16:0] humidity_q22_10;
    logic        pressure_invalid;
  } reading_t;

  // Mirror of the calibration registers
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_hi;
  logic [47:0] cal_mixed;
  logic [31:0] cal_hum;

  reading_t compensated_q[$];

  function automatic logic [31:0] shr32s(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] shr64s(input logic [63:0] x, input int n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] quot32(input logic [31:0] x, input int dv);
    int xs;
    xs = $signed(x);
    return 32'(xs / dv);
  endfunction

  // Signed 64-bit quotient by magnitudes, truncating toward zero, wrapping
  function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p,
                                          input logic [15:0] adc_h);
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, d, b, tfine, x1, v5, w2, w3, w4, q;
    logic [63:0] v1, v2, pr, e, f;
    int hs;
    reading_t r;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'd0, cal_press_lo[15:0]};
    p2 = {{48{cal_press_lo[31]}}, cal_press_lo[31:16]};
    p3 = {{48{cal_press_lo[47]}}, cal_press_lo[47:32]};
    p4 = {{48{cal_press_lo[63]}}, cal_press_lo[63:48]};
    p5 = {{48{cal_press_hi[15]}}, cal_press_hi[15:0]};
    p6 = {{48{cal_press_hi[31]}}, cal_press_hi[31:16]};
    p7 = {{48{cal_press_hi[47]}}, cal_press_hi[47:32]};
    p8 = {{48{cal_press_hi[63]}}, cal_press_hi[63:48]};
    p9 = {{48{cal_mixed[15]}}, cal_mixed[15:0]};
    h1 = {24'd0, cal_mixed[23:16]};
    h2 = {{16{cal_mixed[39]}}, cal_mixed[39:24]};
    h3 = {24'd0, cal_mixed[47:40]};
    h4 = {{20{cal_hum[11]}}, cal_hum[11:0]};
    h5 = {{20{cal_hum[23]}}, cal_hum[23:12]};
    h6 = {{24{cal_hum[31]}}, cal_hum[31:24]};

    // Temperature: fine value and hundredths of a degree
    a = ((32'(adc_t) >> 3) - (t1 << 1)) * t2;
    d = (32'(adc_t) >> 4) - t1;
    b = shr32s(shr32s(d * d, 12) * t3, 14);
    tfine = shr32s(a, 11) + b;
    r.temperature_centi = shr32s(tfine * 32'd5 + 32'd128, 8);

    // Humidity, clamped twice
    x1 = tfine - 32'd76800;
    v5 = quot32(32'(adc_h) * 32'd16384 - h4 * 32'd1048576 - h5 * x1 + 32'd16384, 32768);
    w2 = quot32(x1 * h6, 1024);
    w3 = quot32(x1 * h3, 2048);
    w4 = quot32(w2 * (w3 + 32'd32768), 1024) + 32'd2097152;
    w2 = quot32(w4 * h2 + 32'd8192, 16384);
    w3 = v5 * w2;
    q = quot32(w3, 32768);
    w4 = quot32(q * q, 128);
    hs = $signed(w3 - quot32(w4 * h1, 16));
    if (hs < 0) hs = 0;
    if (hs > 419430400) hs = 419430400;
    hs = hs / 4096;
    if (hs > 102400) hs = 102400;
    r.humidity_q22_10 = 17'(hs);

    // Pressure on the 64-bit path
    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = shr64s(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = shr64s(((64'd1 << 47) + v1) * p1, 33);
    pr = '0;
    r.pressure_invalid = (v1 == '0);
    if (v1 != '0) begin
      pr = 64'd1048576 - 64'(adc_p);
      pr = quot64(((pr << 31) - v2) * 64'd3125, v1);
      e = shr64s(p9 * shr64s(pr, 13) * shr64s(pr, 13), 25);
      f = shr64s(p8 * pr, 19);
      pr = shr64s(pr + e + f, 8) + (p7 << 4);
    end
    r.pressure_q24_8 = pr[31:0];
    return r;
  endfunction

  // Track register writes, predict on each reading, compare on each result
  always @(posedge clk) begin
    reading_t want, got;
    if (rst) begin
      cal_temp <= '0;
      cal_press_lo <= '0;
      cal_press_hi <= '0;
      cal_mixed <= '0;
      cal_hum <= '0;
      compensated_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (esc_pkg::reg_idx_t'(paddr[esc_pkg::ADDR_W-1:3]))
          esc_pkg::REG_TEMP:       cal_temp <= pwdata[47:0];
          esc_pkg::REG_PRESS_LOW:  cal_press_lo <= pwdata;
          esc_pkg::REG_PRESS_HIGH: cal_press_hi <= pwdata;
          esc_pkg::REG_MIXED:      cal_mixed <= pwdata[47:0];
          esc_pkg::REG_HUM:        cal_hum <= pwdata[31:0];
          default: ;
        endcase
      end
      if (sensor_mon.valid && sensor_mon.ready)
        compensated_q.push_back(compensate(sensor_mon.raw_temperature,
                                           sensor_mon.raw_pressure,
                                           sensor_mon.raw_humidity));
      if (result_mon.valid && result_mon.ready) begin
        got.temperature_centi = result_mon.temperature_centi;
        got.pressure_q24_8 = result_mon.pressure_q24_8;
        got.humidity_q22_10 = result_mon.humidity_q22_10;
        got.pressure_invalid = result_mon.pressure_invalid;
        if (compensated_q.size() == 0) begin
          $error("result with no reading outstanding");
          errors <= errors + 1;
        end else begin
          want = compensated_q.pop_front();
          if (got != want) errors <= errors + 1;
          if (got.temperature_centi != want.temperature_centi)
            $error("temperature_centi: expected %0d, got %0d",
                   $signed(want.temperature_centi), $signed(got.temperature_centi));
          if (got.pressure_q24_8 != want.pressure_q24_8)
            $error("pressure_q24_8: expected %0d, got %0d",
                   want.pressure_q24_8, got.pressure_q24_8);
          if (got.humidity_q22_10 != want.humidity_q22_10)
            $error("humidity_q22_10: expected %0d, got %0d",
                   want.humidity_q22_10, got.humidity_q22_10);
          if (got.pressure_invalid != want.pressure_invalid)
            $error("pressure_invalid: expected %0d, got %0d",
                   want.pressure_invalid, got.pressure_invalid);
        end
      end
      // Publish the outstanding count after this edge's updates
      pending <= compensated_q.size();
    end
  end

endmodule

// ===== test/env_sensor_compensation_tb.sv =====
module env_sensor_compensation_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int PIPE_WAIT  = 120;
  localparam int HOLD_LEN   = 400;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [esc_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;
  int errors, pending;
  int idle_cycles;
  logic hold_off;

  esc_in_if  sensor_ch();
  esc_out_if result_ch();

  env_sensor_compensation i_dut (
    .clk(clk), .rst(rst),
    .sensor_in(sensor_ch.sink), .result_out(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  env_sensor_compensation_checker i_checker (
    .clk(clk), .rst(rst), .sensor_mon(sensor_ch), .result_mon(result_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (sensor_ch.valid && sensor_ch.ready) || (result_ch.valid && result_ch.ready)
        || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("env_sensor_compensation regression: fail");
      $finish;
    end
  end

  // Result side: stall in changing patterns, with one long hold-off
  initial begin
    int mode, span;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(3) != 0);
          2: result_ch.ready <= ($urandom_range(3) == 0);
          default: result_ch.ready <= ~result_ch.ready;
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic reg_write(input esc_pkg::reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pl,
                                  input logic [63:0] ph, input logic [47:0] mx,
                                  input logic [31:0] hm);
    reg_write(esc_pkg::REG_TEMP, {16'hFFFF, tc});
    reg_write(esc_pkg::REG_PRESS_LOW, pl);
    reg_write(esc_pkg::REG_PRESS_HIGH, ph);
    reg_write(esc_pkg::REG_MIXED, {16'hFFFF, mx});
    reg_write(esc_pkg::REG_HUM, {32'hFFFF_FFFF, hm});
  endtask

  task automatic load_typical();
    load_calibration({16'(-1000), 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'(-10685), 16'd36477},
                     {16'(-14600), 16'd15500, 16'(-7), 16'd140},
                     {8'd0, 16'd370, 8'd75, 16'd6000},
                     {8'd30, 12'd50, 12'd313});
  endtask

  // Offer one reading and hold it until taken; bursts and gaps follow
  int burst_left;

  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp,
                              input logic [15:0] rh);
    sensor_ch.valid <= 1'b1;
    sensor_ch.raw_temperature <= rt;
    sensor_ch.raw_pressure <= rp;
    sensor_ch.raw_humidity <= rh;
    do @(posedge clk); while (!sensor_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      sensor_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      if ($urandom_range(9) < 7)
        send_reading(20'($urandom_range(380000, 640000)), 20'($urandom_range(200000, 480000)),
                     16'($urandom_range(15000, 50000)));
      else
        send_reading(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  task automatic send_corners();
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'hFFFFF, 20'd0, 16'd0);
    send_reading(20'd0, 20'hFFFFF, 16'hFFFF);
    send_reading(20'h80000, 20'h80000, 16'h8000);
    send_reading(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    send_reading(20'd519888, 20'd415148, 16'd29000);
    send_reading(20'd519888, 20'd415148, 16'd0);
    send_reading(20'd519888, 20'd415148, 16'hFFFF);
    send_reading(20'd440064, 20'd1, 16'd1);
    send_reading(20'd600000, 20'd300000, 16'd60000);
    send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_reading(20'h55555, 20'hAAAAA, 16'h5555);
    send_reading(20'd1, 20'd1048575, 16'd40000);
  endtask

  // Wait for every outstanding result, then let the pipeline go quiet
  task automatic drain();
    sensor_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_off = 1'b0;
    burst_left = 0;
    sensor_ch.valid <= 1'b0;
    sensor_ch.raw_temperature <= '0;
    sensor_ch.raw_pressure <= '0;
    sensor_ch.raw_humidity <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients: pressure divisor is zero
    send_corners();
    send_random(60);
    drain();

    load_typical();
    send_corners();
    send_random(300);
    drain();

    // All-ones coefficients
    load_calibration('1, '1, '1, '1, '1);
    send_random(250);
    drain();

    // Random coefficients, with a long result hold-off
    load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                     48'({$urandom, $urandom}), $urandom);
    hold_off = 1'b1;
    send_random(250);
    drain();

    load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                     48'({$urandom, $urandom}), $urandom);
    send_random(200);
    drain();

    load_typical();
    send_random(300);
    drain();

    if (errors == 0 && pending == 0)
      $display("env_sensor_compensation regression: pass");
    else
      $display("env_sensor_compensation regression: fail");
    $finish;
  end

endmodule
